[rtl/core/fcce_pkg.sv]
// shared constants, codes and types of the fat cluster chain engine
`timescale 1ns / 1ps

package fcce_pkg;

    localparam int TABLE_DEPTH = 65536;
    localparam int ENTRY_BITS  = 32;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int IDX_BITS    = 16;
    localparam int LEN_BITS    = 17;
    localparam int DATA_BITS   = 32;
    localparam int PADDR_BITS  = 3;

    typedef logic [ENTRY_BITS-1:0] t_entry;
    typedef logic [LEN_BITS-1:0]   t_len;
    typedef logic [IDX_BITS-1:0]   t_idx;

    localparam t_len LEN_MIN   = t_len'(3);
    localparam t_len LEN_CAP   = (TABLE_DEPTH < 65536) ? t_len'(TABLE_DEPTH) : t_len'(65536);
    localparam t_len LEN_RESET = t_len'(65536);
    localparam t_idx FIRST_DATA = t_idx'(2);
    localparam t_entry EOC_VALUE = t_entry'(32'h0FFF_FFFF);

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_EXTEND = 2'd2,
        OP_FREE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    // register select is paddr[2]
    localparam logic REG_TABLE_LENGTH = 1'b0;
    localparam logic REG_DATA_START   = 1'b1;

endpackage

[rtl/core/fcce_ram.sv]
// generic simple dual port ram, one write port, one registered read port
`timescale 1ns / 1ps

module fcce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/fat_cluster_chain_engine.sv]
// top level: link table engine with next-fit allocation and chain walks
`timescale 1ns / 1ps
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+---------------------------------------
//  request  | in        | i_in_valid / o_in_stall      | i_operation, i_cluster, i_prev_cluster,
//           |           |                              | i_write_value
//  result   | out       | o_out_valid / i_out_stall    | o_status, o_result_cluster,
//           |           |                              | o_entry_value, o_sector_number
//  config   | in        | apb psel/penable/pwrite      | paddr, pwdata, prdata, pready
//
//  one request at a time, all table access goes through one ram with a registered read.
//  extend scans one entry per cycle from the entry after the cursor (up to table_length less
//  the two reserved entries) and, for a nonzero cluster, walks its chain a link at a time by
//  read and check states, as free does. after reset a clearing pass zeroes the table, requests
//  are stalled meanwhile while config writes are taken. a waiting result sits in the output
//  register, so the next request is taken while the result is stalled.

module fat_cluster_chain_engine (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_operation,
    input  logic [fcce_pkg::IDX_BITS-1:0]    i_cluster,
    input  logic [fcce_pkg::IDX_BITS-1:0]    i_prev_cluster,
    input  logic [fcce_pkg::DATA_BITS-1:0]   i_write_value,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [1:0]                       o_status,
    output logic [fcce_pkg::IDX_BITS-1:0]    o_result_cluster,
    output logic [fcce_pkg::DATA_BITS-1:0]   o_entry_value,
    output logic [fcce_pkg::DATA_BITS-1:0]   o_sector_number,
    // config port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fcce_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [fcce_pkg::DATA_BITS-1:0]   pwdata,
    output logic [fcce_pkg::DATA_BITS-1:0]   prdata,
    output logic                             pready
);

    import fcce_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_WAIT,
        S_SEARCH,
        S_EXT_MARK,
        S_WALK_RD,
        S_WALK_CHK,
        S_EXT_LINK,
        S_FREE_RD,
        S_FREE_CHK,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [ADDR_BITS-1:0]  r_clr;
    t_len                  r_table_length;
    logic [DATA_BITS-1:0]  r_data_start;
    t_idx                  r_cursor;

    // working registers of the current request
    t_idx                  r_cluster;
    t_idx                  r_idx;
    t_idx                  r_chk_idx;
    logic                  r_chk_vld;
    t_len                  r_checked;
    t_len                  r_steps;
    logic [DATA_BITS-1:0]  r_c;
    t_idx                  r_found;
    t_status               r_res_status;
    t_idx                  r_res_cluster;
    logic [DATA_BITS-1:0]  r_res_value;

    // output register
    logic                  r_out_valid;
    t_status               r_out_status;
    t_idx                  r_out_cluster;
    logic [DATA_BITS-1:0]  r_out_value;
    logic [DATA_BITS-1:0]  r_out_sector;

    // ram interface
    logic                  ram_we;
    logic [ADDR_BITS-1:0]  ram_waddr;
    t_entry                ram_wdata;
    logic                  ram_re;
    logic [ADDR_BITS-1:0]  ram_raddr;
    t_entry                ram_rdata;

    t_len                  len;
    logic                  in_accept;
    t_op                   op;
    logic                  range_err;
    t_len                  start_idx;
    t_len                  idx_inc;
    t_idx                  next_idx;
    logic [DATA_BITS-1:0]  rd_value;
    logic [DATA_BITS-1:0]  len_wide;
    logic                  out_free;
    logic                  cfg_write;

    fcce_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // effective table length clamped to the legal range
    always_comb begin
        if (r_table_length < LEN_MIN) begin
            len = LEN_MIN;
        end else if (r_table_length > LEN_CAP) begin
            len = LEN_CAP;
        end else begin
            len = r_table_length;
        end
    end

    assign len_wide  = DATA_BITS'(len);
    assign rd_value  = DATA_BITS'(ram_rdata);
    assign op        = t_op'(i_operation);
    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign range_err = (t_len'(i_cluster) >= len)
                    || (op == OP_FREE && i_prev_cluster != '0 && t_len'(i_prev_cluster) >= len);
    assign out_free  = !r_out_valid || !i_out_stall;

    // scan start: entry after the cursor, wrapping to the first data cluster
    always_comb begin
        start_idx = t_len'(r_cursor) + t_len'(1);
        if (start_idx < t_len'(FIRST_DATA) || start_idx >= len) begin
            start_idx = t_len'(FIRST_DATA);
        end
    end

    assign idx_inc  = t_len'(r_idx) + t_len'(1);
    assign next_idx = (idx_inc >= len) ? FIRST_DATA : t_idx'(idx_inc);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
            end
            S_IDLE: begin
                if (in_accept && !range_err) begin
                    case (op)
                        OP_READ: begin
                            ram_re    = 1'b1;
                            ram_raddr = ADDR_BITS'(i_cluster);
                        end
                        OP_WRITE: begin
                            ram_we    = 1'b1;
                            ram_waddr = ADDR_BITS'(i_cluster);
                            ram_wdata = t_entry'(i_write_value);
                        end
                        OP_FREE: begin
                            // terminate the previous entry before the walk
                            ram_we    = (i_prev_cluster != '0);
                            ram_waddr = ADDR_BITS'(i_prev_cluster);
                            ram_wdata = EOC_VALUE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                ram_re    = 1'b1;
                ram_raddr = ADDR_BITS'(r_idx);
            end
            S_EXT_MARK: begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_BITS'(r_found);
                ram_wdata = EOC_VALUE;
            end
            S_WALK_RD, S_FREE_RD: begin
                ram_re    = 1'b1;
                ram_raddr = ADDR_BITS'(r_c);
            end
            S_EXT_LINK: begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_BITS'(r_c);
                ram_wdata = t_entry'(r_found);
            end
            S_FREE_CHK: begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_BITS'(r_c);
                ram_wdata = '0;
            end
            default: begin
            end
        endcase
    end

    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr          <= '0;
            r_table_length <= LEN_RESET;
            r_data_start   <= '0;
            r_cursor       <= '0;
            r_chk_vld      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (cfg_write) begin
                if (paddr[2] == REG_TABLE_LENGTH) begin
                    r_table_length <= t_len'(pwdata);
                end else begin
                    r_data_start <= pwdata;
                end
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_BITS'(TABLE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_cluster     <= i_cluster;
                        r_res_status  <= ST_OK;
                        r_res_cluster <= i_cluster;
                        r_res_value   <= '0;
                        r_steps       <= '0;
                        r_c           <= DATA_BITS'(i_cluster);
                        if (range_err) begin
                            r_res_status  <= ST_RANGE;
                            r_res_cluster <= '0;
                            r_state       <= S_DONE;
                        end else begin
                            case (op)
                                OP_READ: begin
                                    r_state <= S_RD_WAIT;
                                end
                                OP_WRITE: begin
                                    r_res_value <= DATA_BITS'(t_entry'(i_write_value));
                                    r_state     <= S_DONE;
                                end
                                OP_EXTEND: begin
                                    r_idx     <= t_idx'(start_idx);
                                    r_checked <= '0;
                                    r_chk_vld <= 1'b0;
                                    r_state   <= S_SEARCH;
                                end
                                default: begin
                                    r_state <= S_FREE_RD;
                                end
                            endcase
                        end
                    end
                end
                S_RD_WAIT: begin
                    r_res_value <= rd_value;
                    r_state     <= S_DONE;
                end
                S_SEARCH: begin
                    // one read issued per cycle, the previous one checked
                    r_chk_idx <= r_idx;
                    r_chk_vld <= 1'b1;
                    r_idx     <= next_idx;
                    if (r_chk_vld) begin
                        if (ram_rdata == '0) begin
                            r_found       <= r_chk_idx;
                            r_res_cluster <= r_chk_idx;
                            r_res_value   <= DATA_BITS'(EOC_VALUE);
                            r_chk_vld     <= 1'b0;
                            r_state       <= S_EXT_MARK;
                        end else if (r_checked + t_len'(1) == len - t_len'(FIRST_DATA)) begin
                            r_res_status  <= ST_NO_FREE;
                            r_res_cluster <= '0;
                            r_chk_vld     <= 1'b0;
                            r_state       <= S_DONE;
                        end else begin
                            r_checked <= r_checked + t_len'(1);
                        end
                    end
                end
                S_EXT_MARK: begin
                    r_cursor <= r_found;
                    r_state  <= (r_cluster != '0) ? S_WALK_RD : S_DONE;
                end
                S_WALK_RD: begin
                    if (r_steps == len) begin
                        r_state <= S_EXT_LINK;
                    end else begin
                        r_steps <= r_steps + t_len'(1);
                        r_state <= S_WALK_CHK;
                    end
                end
                S_WALK_CHK: begin
                    if (ram_rdata == EOC_VALUE || rd_value >= len_wide) begin
                        r_state <= S_EXT_LINK;
                    end else begin
                        r_c     <= rd_value;
                        r_state <= S_WALK_RD;
                    end
                end
                S_EXT_LINK: begin
                    r_state <= S_DONE;
                end
                S_FREE_RD: begin
                    // end of chain also shows up here as an index beyond the table
                    if (r_steps == len || r_c >= len_wide) begin
                        r_state <= S_DONE;
                    end else begin
                        r_steps <= r_steps + t_len'(1);
                        r_state <= S_FREE_CHK;
                    end
                end
                S_FREE_CHK: begin
                    if (r_c == DATA_BITS'(r_cursor)) begin
                        r_cursor <= FIRST_DATA;
                    end
                    r_c     <= rd_value;
                    r_state <= S_FREE_RD;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_status  <= r_res_status;
                        r_out_cluster <= r_res_cluster;
                        r_out_value   <= r_res_value;
                        r_out_sector  <= r_data_start + DATA_BITS'(r_res_cluster)
                                       - DATA_BITS'(FIRST_DATA);
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_result_cluster = r_out_cluster;
    assign o_entry_value    = r_out_value;
    assign o_sector_number  = r_out_sector;

    assign prdata = (paddr[2] == REG_TABLE_LENGTH) ? DATA_BITS'(r_table_length) : r_data_start;
    assign pready = 1'b1;

endmodule
